// File: design/rsa_ste_pkg.sv
// Shared constants for the sign-then-encrypt character block.
// No dependencies; imported by the controller and the top level.
package rsa_ste_pkg;

    // Input character field and its byte-padded stream width.
    localparam int CHAR_BITS     = 7;
    localparam int IN_TDATA_BITS = ((CHAR_BITS + 7) / 8) * 8;

    // Digest multiplier applied to the character code.
    localparam logic [CHAR_BITS-1:0] DIGEST_PRIME = 7'd97;

    // Configuration register indexes.
    localparam int CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_A_EXPONENT = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_A_MODULUS  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_B_EXPONENT = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_B_MODULUS  = 2'd3;

endpackage

// File: design/rsa_sign_then_encrypt_char.sv
// Top level of the sign-then-encrypt character block: key registers,
// stream ports and output register. Depends on rsa_ste_pkg and rsa_ste_ctrl.
//
//  Channel   Direction  Beat contents
//  s_axis    in         tdata[6:0] character
//  m_axis    out        tdata[MODULUS_BITS-1:0] cipher_value
//  i_cfg_*   in         write of key register i_cfg_index
//
// One character takes two modular exponentiations on one shared bit-serial
// modular multiplier; each exponentiation needs one reduction and up to
// 2*MODULUS_BITS-1 products, and none when a shortcut applies.
// Reset is synchronous and active low and loads the key registers.
// A result waits in the output register; the next character is taken
// meanwhile and only its finished result stalls until the register frees.
module rsa_sign_then_encrypt_char #(
    parameter int MODULUS_BITS = 31
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Input stream.
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [rsa_ste_pkg::IN_TDATA_BITS-1:0]  s_axis_tdata,  // [6:0] character
    // Output stream.
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [((MODULUS_BITS+7)/8)*8-1:0]      m_axis_tdata,  // cipher_value
    // Configuration writes.
    input  logic                                   i_cfg_wr_en,
    input  logic [rsa_ste_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [MODULUS_BITS-1:0]                i_cfg_data
);

    import rsa_ste_pkg::*;

    localparam int OUT_TDATA_BITS = ((MODULUS_BITS + 7) / 8) * 8;

    logic [MODULUS_BITS-1:0] r_a_exp, r_a_mod, r_b_exp, r_b_mod;
    logic                    r_out_valid, n_out_valid;
    logic [MODULUS_BITS-1:0] r_out_data, n_out_data;

    logic                    w_idle;
    logic                    w_res_valid;
    logic                    w_res_ready;
    logic [MODULUS_BITS-1:0] w_result;

    // Key registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_exp <= MODULUS_BITS'(1);
            r_a_mod <= MODULUS_BITS'(2);
            r_b_exp <= MODULUS_BITS'(1);
            r_b_mod <= MODULUS_BITS'(2);
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_A_EXPONENT: r_a_exp <= i_cfg_data;
                CFG_A_MODULUS:  r_a_mod <= i_cfg_data;
                CFG_B_EXPONENT: r_b_exp <= i_cfg_data;
                CFG_B_MODULUS:  r_b_mod <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    rsa_ste_ctrl #(
        .MODULUS_BITS(MODULUS_BITS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (s_axis_tvalid && w_idle),
        .i_character  (s_axis_tdata[CHAR_BITS-1:0]),
        .i_a_exponent (r_a_exp),
        .i_a_modulus  (r_a_mod),
        .i_b_exponent (r_b_exp),
        .i_b_modulus  (r_b_mod),
        .i_res_ready  (w_res_ready),
        .o_idle       (w_idle),
        .o_res_valid  (w_res_valid),
        .o_result     (w_result)
    );

    // Output register: free when empty or when its beat is taken.
    assign w_res_ready = !r_out_valid || m_axis_tready;

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        if (w_res_valid && w_res_ready) begin
            n_out_valid = 1'b1;
            n_out_data  = w_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
        r_out_data <= n_out_data;
    end

    assign s_axis_tready = w_idle;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_BITS'(r_out_data);

endmodule

// File: design/rsa_ste_modmul.sv
// Bit-serial modular multiplier: result = (a * b) mod n, one bit of b per cycle.
// Requires a < n. A modulus of zero or one yields zero. No package dependency.
module rsa_ste_modmul #(
    parameter int MODULUS_BITS = 31
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [MODULUS_BITS-1:0] i_a,
    input  logic [MODULUS_BITS-1:0] i_b,
    input  logic [MODULUS_BITS-1:0] i_n,
    output logic                    o_done,
    output logic [MODULUS_BITS-1:0] o_result
);

    localparam int CNT_BITS = $clog2(MODULUS_BITS);
    localparam int SUM_BITS = MODULUS_BITS + 2;

    logic                    r_busy, n_busy;
    logic                    r_done, n_done;
    logic [CNT_BITS-1:0]     r_cnt, n_cnt;
    logic [MODULUS_BITS-1:0] r_acc, n_acc;
    logic [MODULUS_BITS-1:0] r_a, n_a;
    logic [MODULUS_BITS-1:0] r_b, n_b;
    logic [MODULUS_BITS-1:0] r_n, n_n;
    logic                    r_small, n_small;

    logic [SUM_BITS-1:0] w_sum;
    logic [SUM_BITS-1:0] w_n1;
    logic [SUM_BITS-1:0] w_n2;
    logic [SUM_BITS-1:0] w_red;

    // One step: acc = 2*acc + bit*a, then bring back below n (sum stays below 3n).
    always_comb begin
        w_sum = {1'b0, r_acc, 1'b0}
              + (r_b[MODULUS_BITS-1] ? SUM_BITS'(r_a) : '0);
        w_n1  = SUM_BITS'(r_n);
        w_n2  = {1'b0, r_n, 1'b0};
        if (w_sum >= w_n2) begin
            w_red = w_sum - w_n2;
        end else if (w_sum >= w_n1) begin
            w_red = w_sum - w_n1;
        end else begin
            w_red = w_sum;
        end
    end

    // Sequencing of the operand bits, most significant first.
    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_acc   = r_acc;
        n_a     = r_a;
        n_b     = r_b;
        n_n     = r_n;
        n_small = r_small;
        if (i_start) begin
            n_busy  = 1'b1;
            n_cnt   = CNT_BITS'(MODULUS_BITS - 1);
            n_acc   = '0;
            n_a     = i_a;
            n_b     = i_b;
            n_n     = i_n;
            n_small = (i_n <= MODULUS_BITS'(1));
        end else if (r_busy) begin
            n_acc = r_small ? '0 : w_red[MODULUS_BITS-1:0];
            n_b   = {r_b[MODULUS_BITS-2:0], 1'b0};
            n_cnt = r_cnt - CNT_BITS'(1);
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt   <= n_cnt;
        r_acc   <= n_acc;
        r_a     <= n_a;
        r_b     <= n_b;
        r_n     <= n_n;
        r_small <= n_small;
    end

    assign o_done   = r_done;
    assign o_result = r_acc;

endmodule

// File: design/rsa_ste_ctrl.sv
// Sequencer for the two square-and-multiply exponentiations of one character.
// Uses rsa_ste_pkg and drives the shared rsa_ste_modmul unit.
module rsa_ste_ctrl #(
    parameter int MODULUS_BITS = 31
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [rsa_ste_pkg::CHAR_BITS-1:0] i_character,
    input  logic [MODULUS_BITS-1:0]          i_a_exponent,
    input  logic [MODULUS_BITS-1:0]          i_a_modulus,
    input  logic [MODULUS_BITS-1:0]          i_b_exponent,
    input  logic [MODULUS_BITS-1:0]          i_b_modulus,
    input  logic                             i_res_ready,
    output logic                             o_idle,
    output logic                             o_res_valid,
    output logic [MODULUS_BITS-1:0]          o_result
);

    import rsa_ste_pkg::*;

    localparam int DIGEST_BITS = 2 * CHAR_BITS;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SETUP  = 4'd1;
    localparam logic [3:0] S_CHECK  = 4'd2;
    localparam logic [3:0] S_REDUCE = 4'd3;
    localparam logic [3:0] S_BIT    = 4'd4;
    localparam logic [3:0] S_MULR   = 4'd5;
    localparam logic [3:0] S_SQCHK  = 4'd6;
    localparam logic [3:0] S_SQR    = 4'd7;
    localparam logic [3:0] S_STEND  = 4'd8;
    localparam logic [3:0] S_FINISH = 4'd9;

    logic [3:0]              r_state, n_state;
    logic                    r_stage, n_stage;
    logic [MODULUS_BITS-1:0] r_x, n_x;
    logic [MODULUS_BITS-1:0] r_r, n_r;
    logic [MODULUS_BITS-1:0] r_y, n_y;
    logic [MODULUS_BITS-1:0] r_n, n_n;

    logic                    w_swap;
    logic                    w_shortcut;
    logic                    w_mm_start;
    logic [MODULUS_BITS-1:0] w_mm_a;
    logic [MODULUS_BITS-1:0] w_mm_b;
    logic                    w_mm_done;
    logic [MODULUS_BITS-1:0] w_mm_res;
    logic [DIGEST_BITS-1:0]  w_digest;

    // Key order: the smaller modulus signs first; on equal moduli key A signs.
    assign w_swap     = (i_b_modulus < i_a_modulus);
    assign w_digest   = DIGEST_BITS'(i_character) * DIGEST_BITS'(DIGEST_PRIME);
    assign w_shortcut = (r_x == MODULUS_BITS'(0)) || (r_x == MODULUS_BITS'(1))
                     || (r_y == MODULUS_BITS'(1));

    // Operand selection for the shared multiplier.
    always_comb begin
        w_mm_start = 1'b0;
        w_mm_a     = r_x;
        w_mm_b     = r_x;
        unique case (r_state)
            S_CHECK: begin
                w_mm_a     = MODULUS_BITS'(1);
                w_mm_start = !w_shortcut && (r_y != '0);
            end
            S_BIT: begin
                w_mm_a     = r_r;
                w_mm_start = r_y[0];
            end
            S_SQCHK: begin
                w_mm_start = (r_y[MODULUS_BITS-1:1] != '0);
            end
            default: begin
                w_mm_start = 1'b0;
            end
        endcase
    end

    // Exponentiation sequencer.
    always_comb begin
        n_state = r_state;
        n_stage = r_stage;
        n_x     = r_x;
        n_r     = r_r;
        n_y     = r_y;
        n_n     = r_n;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_x     = MODULUS_BITS'(w_digest);
                    n_stage = 1'b0;
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                if (w_swap ^ r_stage) begin
                    n_y = i_b_exponent;
                    n_n = i_b_modulus;
                end else begin
                    n_y = i_a_exponent;
                    n_n = i_a_modulus;
                end
                n_r     = MODULUS_BITS'(1);
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (w_shortcut) begin
                    n_r     = r_x;
                    n_state = S_STEND;
                end else if (r_y == '0) begin
                    n_state = S_STEND;
                end else begin
                    n_state = S_REDUCE;
                end
            end
            S_REDUCE: begin
                if (w_mm_done) begin
                    n_x     = w_mm_res;
                    n_state = S_BIT;
                end
            end
            S_BIT: begin
                n_state = r_y[0] ? S_MULR : S_SQCHK;
            end
            S_MULR: begin
                if (w_mm_done) begin
                    n_r     = w_mm_res;
                    n_state = S_SQCHK;
                end
            end
            S_SQCHK: begin
                if (r_y[MODULUS_BITS-1:1] == '0) begin
                    n_state = S_STEND;
                end else begin
                    n_y     = r_y >> 1;
                    n_state = S_SQR;
                end
            end
            S_SQR: begin
                if (w_mm_done) begin
                    n_x     = w_mm_res;
                    n_state = S_BIT;
                end
            end
            S_STEND: begin
                if (!r_stage) begin
                    n_x     = r_r;
                    n_stage = 1'b1;
                    n_state = S_SETUP;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_stage <= 1'b0;
        end else begin
            r_state <= n_state;
            r_stage <= n_stage;
        end
        r_x <= n_x;
        r_r <= n_r;
        r_y <= n_y;
        r_n <= n_n;
    end

    rsa_ste_modmul #(
        .MODULUS_BITS(MODULUS_BITS)
    ) u_modmul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_mm_start),
        .i_a      (w_mm_a),
        .i_b      (w_mm_b),
        .i_n      (r_n),
        .o_done   (w_mm_done),
        .o_result (w_mm_res)
    );

    assign o_idle      = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_FINISH);
    assign o_result    = r_r;

endmodule

// File: design/rsa_ste_checker.sv
// Port-level assertions for the sign-then-encrypt character block.
// Depends on rsa_ste_pkg; bound to rsa_sign_then_encrypt_char below.
module rsa_ste_sva #(
    parameter int MODULUS_BITS = 31
) (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  s_axis_tvalid,
    input logic                                  s_axis_tready,
    input logic                                  m_axis_tvalid,
    input logic                                  m_axis_tready,
    input logic [((MODULUS_BITS+7)/8)*8-1:0]     m_axis_tdata
);

    import rsa_ste_pkg::*;

    // A stalled output beat stays offered.
    a_out_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output beat dropped while stalled");

    // A stalled output beat keeps its data.
    a_out_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output data changed while stalled");

    // One character at a time: the block is busy right after taking one.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken again in the cycle after a beat");

    // Reset leaves no result on the output.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind rsa_sign_then_encrypt_char rsa_ste_sva #(
    .MODULUS_BITS(MODULUS_BITS)
) u_rsa_ste_sva (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// File: verif/rsa_ste_checker.sv
// Scoreboard for the sign-then-encrypt character block: watches the key writes
// and both stream channels, predicts each cipher value and compares the results.
// Depends on rsa_ste_pkg for the input width and the key register indexes.
module rsa_ste_checker #(
    parameter int MODULUS_BITS = 31
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Input stream, observed only.
    input  logic                                   s_axis_tvalid,
    input  logic                                   s_axis_tready,
    input  logic [rsa_ste_pkg::IN_TDATA_BITS-1:0]  s_axis_tdata,  // [6:0] character
    // Output stream, observed only.
    input  logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    input  logic [((MODULUS_BITS+7)/8)*8-1:0]      m_axis_tdata,  // cipher_value
    // Key register writes, observed only.
    input  logic                                   i_cfg_wr_en,
    input  logic [rsa_ste_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [MODULUS_BITS-1:0]                i_cfg_data,
    // Cipher values still owed by the block, and the mismatch count.
    output int                                     o_pending,
    output int                                     o_fail_count
);

    localparam longint unsigned DIGEST_FACTOR = 97;
    localparam longint unsigned CIPHER_MASK   = (64'd1 << MODULUS_BITS) - 1;

    // Shadow copy of the four key registers.
    logic [MODULUS_BITS-1:0] a_exp;
    logic [MODULUS_BITS-1:0] a_mod;
    logic [MODULUS_BITS-1:0] b_exp;
    logic [MODULUS_BITS-1:0] b_mod;

    longint unsigned cipher_q[$];
    int              fails = 0;

    assign o_fail_count = fails;

    // Square-and-multiply, with the shortcuts that return the base unreduced.
    function automatic longint unsigned expmod(longint unsigned base,
                                               longint unsigned power,
                                               longint unsigned modulus);
        longint unsigned acc;
        longint unsigned sq;
        longint unsigned bits;
        longint unsigned n;
        acc  = 1;
        sq   = base;
        bits = power;
        n    = modulus;
        if (sq == 0 || sq == 1 || bits == 1) begin
            return sq;
        end
        // A zero modulus behaves as a modulus of one.
        if (n == 0) begin
            n = 1;
        end
        sq = sq % n;
        while (bits != 0) begin
            if (bits[0]) begin
                acc = (acc * sq) % n;
            end
            sq   = (sq * sq) % n;
            bits = bits >> 1;
        end
        return acc;
    endfunction

    // Sign the digest with one key, then encrypt the signature with the other.
    // The key with the smaller modulus signs when B's modulus is below A's.
    function automatic longint unsigned cipher_of(logic [rsa_ste_pkg::CHAR_BITS-1:0] code);
        longint unsigned digest;
        longint unsigned signature;
        digest = DIGEST_FACTOR * longint'(code);
        if (b_mod < a_mod) begin
            signature = expmod(digest, b_exp, b_mod);
            return expmod(signature, a_exp, a_mod) & CIPHER_MASK;
        end
        signature = expmod(digest, a_exp, a_mod);
        return expmod(signature, b_exp, b_mod) & CIPHER_MASK;
    endfunction

    task automatic report(string what, longint unsigned got, longint unsigned want);
        $display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, want);
        fails++;
    endtask

    // Track key writes, queue a prediction per input beat, check each output beat.
    always @(posedge i_clk) begin
        longint unsigned want;
        if (!i_rst_n) begin
            a_exp     <= 1;
            a_mod     <= 2;
            b_exp     <= 1;
            b_mod     <= 2;
            cipher_q.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    rsa_ste_pkg::CFG_A_EXPONENT: a_exp <= i_cfg_data;
                    rsa_ste_pkg::CFG_A_MODULUS:  a_mod <= i_cfg_data;
                    rsa_ste_pkg::CFG_B_EXPONENT: b_exp <= i_cfg_data;
                    rsa_ste_pkg::CFG_B_MODULUS:  b_mod <= i_cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                cipher_q.push_back(cipher_of(s_axis_tdata[rsa_ste_pkg::CHAR_BITS-1:0]));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (cipher_q.size() == 0) begin
                    report("unexpected result beat", m_axis_tdata, 0);
                end else begin
                    want = cipher_q.pop_front();
                    if (m_axis_tdata[MODULUS_BITS-1:0] != want) begin
                        report("cipher_value", m_axis_tdata[MODULUS_BITS-1:0], want);
                    end
                    if ((m_axis_tdata >> MODULUS_BITS) != 0) begin
                        report("tdata padding", m_axis_tdata >> MODULUS_BITS, 0);
                    end
                end
            end
            o_pending <= cipher_q.size();
        end
    end

endmodule

// File: verif/rsa_sign_then_encrypt_char_tb.sv
// Testbench top for the sign-then-encrypt character block: clock, reset, key
// writes, character beats and output back-pressure. Depends on rsa_ste_pkg,
// the block itself and rsa_ste_checker, which predicts and compares.
module rsa_sign_then_encrypt_char_tb;

    localparam int KEY_BITS       = 31;
    localparam int CHAR_BITS      = rsa_ste_pkg::CHAR_BITS;
    localparam int IN_BITS        = rsa_ste_pkg::IN_TDATA_BITS;
    localparam int OUT_TDATA_BITS = ((KEY_BITS + 7) / 8) * 8;
    localparam logic [KEY_BITS-1:0] KEY_MAX = '1;

    logic                                   i_clk;
    logic                                   i_rst_n;
    logic                                   s_axis_tvalid;
    logic                                   s_axis_tready;
    logic [IN_BITS-1:0]                     s_axis_tdata;
    logic                                   m_axis_tvalid;
    logic                                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_BITS-1:0]              m_axis_tdata;
    logic                                   i_cfg_wr_en;
    logic [rsa_ste_pkg::CFG_INDEX_BITS-1:0] i_cfg_index;
    logic [KEY_BITS-1:0]                    i_cfg_data;

    // No random idling on either side while this is set.
    logic steady = 1'b0;
    int   pending;
    int   fail_count;

    rsa_sign_then_encrypt_char #(
        .MODULUS_BITS(KEY_BITS)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    rsa_ste_checker #(
        .MODULUS_BITS(KEY_BITS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // Clock with a period of 10.
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Output back-pressure: tready drops at random with a chance of 12 in a hundred unless steady is set.
    always @(posedge i_clk) begin
        m_axis_tready <= i_rst_n && (steady || $urandom_range(0, 99) >= 12);
    end

    task automatic write_key(logic [rsa_ste_pkg::CFG_INDEX_BITS-1:0] index,
                             logic [KEY_BITS-1:0] value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
    endtask

    task automatic write_keys(logic [KEY_BITS-1:0] a_exp, logic [KEY_BITS-1:0] a_mod,
                              logic [KEY_BITS-1:0] b_exp, logic [KEY_BITS-1:0] b_mod);
        write_key(rsa_ste_pkg::CFG_A_EXPONENT, a_exp);
        write_key(rsa_ste_pkg::CFG_A_MODULUS, a_mod);
        write_key(rsa_ste_pkg::CFG_B_EXPONENT, b_exp);
        write_key(rsa_ste_pkg::CFG_B_MODULUS, b_mod);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    // Present one character beat, after an occasional idle gap.
    task automatic send_char(logic [rsa_ste_pkg::CHAR_BITS-1:0] code);
        while (!steady && $urandom_range(0, 99) < 12) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_BITS'(code);
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
    endtask

    // Hold the input quiet until every cipher value has come back.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Mostly short exponents keep the run fast; wide ones use all 31 bits.
    function automatic logic [KEY_BITS-1:0] rand_exponent(bit wide);
        int unsigned         len;
        logic [KEY_BITS-1:0] value;
        if (wide) begin
            return KEY_BITS'($urandom);
        end
        len   = $urandom_range(0, 16);
        value = KEY_BITS'($urandom) & ((KEY_BITS'(1) << len) - KEY_BITS'(1));
        if (len > 0) begin
            value = value | (KEY_BITS'(1) << (len - 1));
        end
        return value;
    endfunction

    // Moduli range from degenerate (zero and one) to full width.
    function automatic logic [KEY_BITS-1:0] rand_modulus();
        case ($urandom_range(0, 9))
            0:             return KEY_BITS'($urandom_range(0, 3));
            1, 2, 3, 4, 5: return KEY_BITS'($urandom_range(2, 65535));
            default:       return KEY_BITS'($urandom);
        endcase
    endfunction

    initial begin
        int unsigned phase;
        int unsigned k;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_data    <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset keys: exponent one passes the digest through unreduced.
        send_char(0);
        send_char(127);
        send_char(1);
        drain();

        // Zero exponents with zero and unit moduli.
        write_keys(0, 0, 0, 1);
        send_char(0);
        send_char(1);
        send_char(5);
        drain();

        // Largest exponent and modulus, equal moduli keep the default order.
        write_keys(KEY_MAX, KEY_MAX, 65537, KEY_MAX);
        send_char(127);
        send_char(3);
        send_char(64);
        drain();

        // B's modulus below A's: the keys swap roles.
        write_keys(17, 3233, 2753, 61);
        send_char(65);
        send_char(66);
        send_char(127);
        send_char(0);
        drain();

        // Modulus of one reduces everything to zero.
        write_keys(5, 1, 3, 1);
        send_char(2);
        send_char(100);
        drain();

        // Random keys per phase; one phase with wide exponents, one with no idling.
        for (phase = 0; phase < 6; phase++) begin
            steady <= (phase == 4);
            write_keys(rand_exponent(phase == 2), rand_modulus(),
                       rand_exponent(phase == 2), rand_modulus());
            for (k = 0; k < 16; k++) begin
                send_char(CHAR_BITS'($urandom_range(0, 127)));
            end
            drain();
        end

        repeat (50) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog, several times the slowest legal run.
    initial begin
        #(30_000_000);
        $display("TEST FAILED");
        $finish;
    end

endmodule

// File: files.f
design/rsa_ste_pkg.sv
design/rsa_ste_modmul.sv
design/rsa_ste_ctrl.sv
design/rsa_sign_then_encrypt_char.sv
design/rsa_ste_checker.sv
verif/rsa_ste_checker.sv
verif/rsa_sign_then_encrypt_char_tb.sv
